### rtl/ccpt_pkg.sv
// ----------------------------------------------------------------------------
// ccpt_pkg
// Shared constants, codes and types of the cubic curve point and tangent
// evaluator.
// ----------------------------------------------------------------------------
package ccpt_pkg;

	// Point store geometry. The store is cut into four banks so that the four
	// consecutive points of one segment come from four different banks.
	localparam int STORE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int BANKS       = 4;
	localparam int ROWS        = STORE_DEPTH / BANKS;
	localparam int ROW_W       = $clog2(ROWS);

	// Base index of a segment reaches at most three times 254.
	localparam int BASE_W = 10;
	localparam int CMP_W  = 14;

	// Fixed point constants.
	localparam logic [16:0] T_ONE   = 17'h1_0000;
	localparam logic [33:0] DIV3_M  = 34'h2_AAAA_AAAB;

	// Configuration register indexes.
	localparam logic [1:0] CFG_KIND    = 2'd0;
	localparam logic [1:0] CFG_POINTS  = 2'd1;
	localparam logic [1:0] CFG_TENSION = 2'd2;

	typedef enum logic [1:0] {
		KIND_LINEAR   = 2'd0,
		KIND_BEZIER   = 2'd1,
		KIND_BSPLINE  = 2'd2,
		KIND_CARDINAL = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_LOAD = 2'd0,
		MODE_POS  = 2'd1,
		MODE_TAN  = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	// Final divisor of the weighted sum.
	typedef enum logic [1:0] {
		DIV_1 = 2'd0,
		DIV_2 = 2'd1,
		DIV_6 = 2'd2
	} dsel_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  idx;
		point_t      pt;
		logic [16:0] u;
	} item_t;

	// Resolved request leaving the front end.
	typedef struct packed {
		logic              ev;
		logic              ld;
		logic              tan;
		logic              one_pt;
		dsel_t             dsel;
		logic [3:0]        mask;
		logic              fault;
		logic [BASE_W-1:0] base;
		logic [16:0]       f;
		logic [7:0]        idx;
		point_t            pt;
	} req_t;

	// Control that travels with an evaluation down the arithmetic stages.
	typedef struct packed {
		logic       valid;
		logic       fault;
		logic       tan;
		logic       one_pt;
		logic [3:0] mask;
		dsel_t      dsel;
	} ctl_t;

endpackage

### rtl/cubic_curve_point_and_tangent.sv
// ----------------------------------------------------------------------------
// cubic_curve_point_and_tangent
// Piecewise cubic curve evaluator over a store of 3-D control points.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry a mode: a load beat writes one control point into the
//   store, a position or tangent beat evaluates the curve at curve_param.
//   Each evaluation with curve_param at most one gives one output beat of
//   three saturated Q16.16 values and a range fault flag; loads, the unused
//   mode and parameters above one give no output beat.
//   Configuration registers (curve kind, point count, tension) are written
//   through the plain write port while the block is idle.
//   One beat can enter every cycle unless the pipeline is held by a receiver
//   stall; the rate is set by the eleven-register pipeline with a four-bank
//   store read once per evaluation.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_stall rises; nothing is lost or repeated.
//   Reset clears the pipeline valid bits and the registers to linear, two
//   points, tension one half. The point store is not cleared and must be
//   loaded before it is read.
// ----------------------------------------------------------------------------
module cubic_curve_point_and_tangent (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [1:0]         cfg_index,
	input  logic [19:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [7:0]         point_index,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic [16:0]        curve_param,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_x,
	output logic signed [31:0] result_y,
	output logic signed [31:0] result_z,
	output logic               range_fault
);
	import ccpt_pkg::*;

	kind_t              kind_q;
	logic [7:0]         points_q;
	logic signed [19:0] tension_q;
	logic               en;
	logic               valid_s1;
	item_t              item_s1;
	req_t               req_s3;
	point_t             pts_s4 [4];
	ctl_t               ctl_s7;
	logic signed [31:0] w_s7 [4];
	logic signed [31:0] res_s11 [3];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= KIND_LINEAR;
			points_q  <= 8'd2;
			tension_q <= 20'sd32768;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_KIND:    kind_q    <= kind_t'(cfg_data[1:0]);
				CFG_POINTS:  points_q  <= cfg_data[7:0];
				CFG_TENSION: tension_q <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// The pipeline advances unless a finished beat is held by the receiver.
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1.mode <= mode_t'(mode);
			item_s1.idx  <= point_index;
			item_s1.pt   <= '{x: coord_x, y: coord_y, z: coord_z};
			item_s1.u    <= curve_param;
		end
	end

	ccpt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.kind     (kind_q),
		.points   (points_q),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.req_s3   (req_s3)
	);

	ccpt_store u_store (
		.clk    (clk),
		.en     (en),
		.req_s3 (req_s3),
		.pts_s4 (pts_s4)
	);

	ccpt_weights u_weights (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.kind    (kind_q),
		.tension (tension_q),
		.req_s3  (req_s3),
		.ctl_s7  (ctl_s7),
		.w_s7    (w_s7)
	);

	ccpt_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.pts_s4    (pts_s4),
		.ctl_s7    (ctl_s7),
		.w_s7      (w_s7),
		.valid_s11 (out_valid),
		.res_s11   (res_s11),
		.fault_s11 (range_fault)
	);

	assign result_x = res_s11[0];
	assign result_y = res_s11[1];
	assign result_z = res_s11[2];

endmodule

### rtl/ccpt_front.sv
// ----------------------------------------------------------------------------
// ccpt_front
// Splits the curve parameter into segment and fraction, resolves the end
// cases, and forms the base index, point mask and range fault.
// ----------------------------------------------------------------------------
module ccpt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  ccpt_pkg::kind_t kind,
	input  logic [7:0]      points,
	input  logic            valid_s1,
	input  ccpt_pkg::item_t item_s1,
	output ccpt_pkg::req_t  req_s3
);
	import ccpt_pkg::*;

	logic [7:0]  n1;
	logic [7:0]  nm1_1;
	logic [24:0] p1;
	logic        ev1;
	logic        ld1;

	logic        ev_s2;
	logic        ld_s2;
	logic [24:0] p_s2;
	logic        end_s2;
	logic        tan_s2;
	logic [7:0]  n_s2;
	logic [7:0]  idx_s2;
	point_t      pt_s2;

	req_t        pay2;
	logic        ev_s3;
	logic        ld_s3;
	req_t        pay_s3;

	// Stage one: scale the parameter by the segment count.
	always_comb begin
		n1    = (points < 8'd2) ? 8'd2 : points;
		nm1_1 = n1 - 8'd1;
		p1    = 25'(item_s1.u * nm1_1);
		ev1   = valid_s1 && (item_s1.mode == MODE_POS || item_s1.mode == MODE_TAN) &&
			(item_s1.u <= T_ONE);
		ld1   = valid_s1 && (item_s1.mode == MODE_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s2 <= 1'b0;
			ld_s2 <= 1'b0;
		end else if (en) begin
			ev_s2 <= ev1;
			ld_s2 <= ld1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2   <= p1;
			end_s2 <= (item_s1.u == T_ONE);
			tan_s2 <= (item_s1.mode == MODE_TAN);
			n_s2   <= n1;
			idx_s2 <= item_s1.idx;
			pt_s2  <= item_s1.pt;
		end
	end

	// Stage two: segment, fraction, base index and fault check.
	always_comb begin
		logic [7:0]        seg;
		logic [BASE_W-1:0] nm1w;
		logic [BASE_W-1:0] segw;
		pay2        = '0;
		pay2.tan    = tan_s2;
		pay2.idx    = idx_s2;
		pay2.pt     = pt_s2;
		nm1w        = BASE_W'(n_s2 - 8'd1);
		seg         = end_s2 ? (n_s2 - 8'd2) : p_s2[23:16];
		segw        = BASE_W'(seg);
		if (end_s2) begin
			pay2.f = (tan_s2 && kind == KIND_LINEAR) ? 17'd0 : T_ONE;
		end else begin
			pay2.f = {1'b0, p_s2[15:0]};
		end
		pay2.one_pt = end_s2 && !tan_s2 && (kind != KIND_BSPLINE);
		if (pay2.one_pt) begin
			case (kind)
				KIND_LINEAR: pay2.base = nm1w;
				KIND_BEZIER: pay2.base = (nm1w << 1) + nm1w;
				default:     pay2.base = BASE_W'(n_s2);
			endcase
			pay2.mask = 4'b0001;
		end else begin
			pay2.base = (kind == KIND_BEZIER) ? ((segw << 1) + segw) : segw;
			pay2.mask = (kind == KIND_LINEAR) ? 4'b0011 : 4'b1111;
		end
		pay2.fault = 1'b0;
		for (int k = 0; k < 4; k++) begin
			if (pay2.mask[k] &&
				(CMP_W'(pay2.base) + CMP_W'(k) >= CMP_W'(STORE_DEPTH))) begin
				pay2.fault = 1'b1;
			end
		end
		if (kind == KIND_BSPLINE) begin
			pay2.dsel = tan_s2 ? DIV_2 : DIV_6;
		end else begin
			pay2.dsel = DIV_1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s3 <= 1'b0;
			ld_s3 <= 1'b0;
		end else if (en) begin
			ev_s3 <= ev_s2;
			ld_s3 <= ld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s3 <= pay2;
		end
	end

	always_comb begin
		req_s3    = pay_s3;
		req_s3.ev = ev_s3;
		req_s3.ld = ld_s3;
	end

endmodule

### rtl/ccpt_store.sv
// ----------------------------------------------------------------------------
// ccpt_store
// Four-bank control point store. A load beat writes one bank; an evaluation
// reads the four consecutive points of its segment, one from each bank.
// ----------------------------------------------------------------------------
module ccpt_store (
	input  logic            clk,
	input  logic            en,
	input  ccpt_pkg::req_t  req_s3,
	output ccpt_pkg::point_t pts_s4 [4]
);
	import ccpt_pkg::*;

	logic [ADDR_W-1:0] waddr;
	logic              wok;
	logic [1:0]        rot_s4;
	point_t            rd_s4 [BANKS];

	always_comb begin
		waddr = ADDR_W'(req_s3.idx);
		wok   = (32'(req_s3.idx) < 32'(STORE_DEPTH));
	end

	// One bank per address residue modulo four.
	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		point_t            mem [ROWS];
		logic [1:0]        roff;
		logic [BASE_W-1:0] raddr;
		logic [ROW_W-1:0]  rrow;

		// The offset from the base to this bank's point wraps within four.
		always_comb begin
			roff  = 2'(b) - req_s3.base[1:0];
			raddr = req_s3.base + BASE_W'(roff);
			rrow  = raddr[ADDR_W-1:2];
		end

		always_ff @(posedge clk) begin
			if (en && req_s3.ld && wok && waddr[1:0] == 2'(b)) begin
				mem[waddr[ADDR_W-1:2]] <= req_s3.pt;
			end
			if (en && req_s3.ev) begin
				rd_s4[b] <= mem[rrow];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s4 <= req_s3.base[1:0];
		end
	end

	// Put the bank outputs back in segment order.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			pts_s4[k] = rd_s4[2'(rot_s4 + 2'(k))];
		end
	end

endmodule

### rtl/ccpt_weights.sv
// ----------------------------------------------------------------------------
// ccpt_weights
// Powers of the fraction and the four basis weights, including the
// cardinal tension products, over four pipeline stages.
// ----------------------------------------------------------------------------
module ccpt_weights (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  ccpt_pkg::kind_t    kind,
	input  logic signed [19:0] tension,
	input  ccpt_pkg::req_t     req_s3,
	output ccpt_pkg::ctl_t     ctl_s7,
	output logic signed [31:0] w_s7 [4]
);
	import ccpt_pkg::*;

	ctl_t               ctl3;
	ctl_t               ctl_s4;
	ctl_t               ctl_s5;
	ctl_t               ctl_s6;
	logic [16:0]        f_s4;
	logic [33:0]        ff_s4;
	logic [24:0]        t1_s5;
	logic [24:0]        t2_s5;
	logic [24:0]        t3_s5;
	logic [50:0]        fff4;
	logic signed [31:0] l5 [4];
	logic signed [31:0] x5 [4];
	logic signed [31:0] l_s6 [4];
	logic signed [31:0] x_s6 [4];
	logic signed [51:0] tp6 [4];

	always_comb begin
		ctl3        = '0;
		ctl3.valid  = req_s3.ev;
		ctl3.fault  = req_s3.fault;
		ctl3.tan    = req_s3.tan;
		ctl3.one_pt = req_s3.one_pt;
		ctl3.mask   = req_s3.mask;
		ctl3.dsel   = req_s3.dsel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else if (en) begin
			ctl_s4 <= ctl3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	// Stage three: square of the fraction.
	always_ff @(posedge clk) begin
		if (en) begin
			f_s4  <= req_s3.f;
			ff_s4 <= 34'(req_s3.f * req_s3.f);
		end
	end

	// Stage four: cube, then the Q1.24 powers.
	assign fff4 = 51'(ff_s4 * f_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s5 <= {f_s4, 8'd0};
			t2_s5 <= ff_s4[32:8];
			t3_s5 <= fff4[48:24];
		end
	end

	// Stage five: plain weight parts and tension arguments.
	always_comb begin
		logic signed [31:0] a1;
		logic signed [31:0] a2;
		logic signed [31:0] a3;
		logic signed [31:0] one;
		a1  = signed'({7'd0, t1_s5});
		a2  = signed'({7'd0, t2_s5});
		a3  = signed'({7'd0, t3_s5});
		one = 32'sh0100_0000;
		for (int k = 0; k < 4; k++) begin
			l5[k] = '0;
			x5[k] = '0;
		end
		if (ctl_s5.one_pt) begin
			l5[0] = one;
		end else if (!ctl_s5.tan) begin
			case (kind)
				KIND_LINEAR: begin
					l5[0] = one - a1;
					l5[1] = a1;
				end
				KIND_BEZIER: begin
					l5[0] = one - 3 * a1 + 3 * a2 - a3;
					l5[1] = 3 * a1 - 6 * a2 + 3 * a3;
					l5[2] = 3 * a2 - 3 * a3;
					l5[3] = a3;
				end
				KIND_BSPLINE: begin
					l5[0] = one - 3 * a1 + 3 * a2 - a3;
					l5[1] = 3 * a3 - 6 * a2 + 4 * one;
					l5[2] = 3 * (a2 - a3 + a1) + one;
					l5[3] = a3;
				end
				default: begin
					x5[0] = 2 * a2 - a3 - a1;
					l5[1] = 2 * a3 - 3 * a2 + one;
					x5[1] = a2 - a3;
					l5[2] = 3 * a2 - 2 * a3;
					x5[2] = a3 - 2 * a2 + a1;
					x5[3] = a3 - a2;
				end
			endcase
		end else begin
			case (kind)
				KIND_LINEAR: begin
					l5[0] = -one;
					l5[1] = one;
				end
				KIND_BEZIER: begin
					l5[0] = -3 * one + 6 * a1 - 3 * a2;
					l5[1] = 3 * one - 12 * a1 + 9 * a2;
					l5[2] = 6 * a1 - 9 * a2;
					l5[3] = 3 * a2;
				end
				KIND_BSPLINE: begin
					l5[0] = -(one - 2 * a1 + a2);
					l5[1] = 3 * a2 - 4 * a1;
					l5[2] = -3 * a2 + 2 * a1 + one;
					l5[3] = a2;
				end
				default: begin
					x5[0] = -3 * a2 + 4 * a1 - one;
					l5[1] = 6 * a2 - 6 * a1;
					x5[1] = 2 * a1 - 3 * a2;
					l5[2] = -6 * a2 + 6 * a1;
					x5[2] = 3 * a2 - 4 * a1 + one;
					x5[3] = 3 * a2 - 2 * a1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s6 <= l5;
			x_s6 <= x5;
		end
	end

	// Full-width tension products.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			tp6[k] = tension * x_s6[k];
		end
	end

	// Stage six: tension products, floored, added to the plain parts.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				w_s7[k] <= l_s6[k] + 32'(tp6[k] >>> 16);
			end
		end
	end

endmodule

### rtl/ccpt_mac.sv
// ----------------------------------------------------------------------------
// ccpt_mac
// Weighted sum of the four points per axis, rounding, division by the
// basis divisor and saturation to signed Q16.16.
// ----------------------------------------------------------------------------
module ccpt_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  ccpt_pkg::point_t   pts_s4 [4],
	input  ccpt_pkg::ctl_t     ctl_s7,
	input  logic signed [31:0] w_s7 [4],
	output logic               valid_s11,
	output logic signed [31:0] res_s11 [3],
	output logic               fault_s11
);
	import ccpt_pkg::*;

	point_t             pts_s5 [4];
	point_t             pts_s6 [4];
	point_t             pts_s7 [4];
	ctl_t               ctl_s8;
	ctl_t               ctl_s9;
	ctl_t               ctl_s10;
	logic signed [63:0] prod_s8 [4][3];
	logic signed [34:0] vc8 [3];
	logic signed [34:0] vc_s9 [3];
	logic signed [34:0] vc_s10 [3];
	logic [50:0]        pph_s10 [3];
	logic [50:0]        ppl_s10 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s8    <= '0;
			ctl_s9    <= '0;
			ctl_s10   <= '0;
			valid_s11 <= 1'b0;
		end else if (en) begin
			ctl_s8    <= ctl_s7;
			ctl_s9    <= ctl_s8;
			ctl_s10   <= ctl_s9;
			valid_s11 <= ctl_s10.valid;
		end
	end

	// Align the point data with the weights.
	always_ff @(posedge clk) begin
		if (en) begin
			pts_s5 <= pts_s4;
			pts_s6 <= pts_s5;
			pts_s7 <= pts_s6;
		end
	end

	// Stage seven: one product per point and axis; unused points count zero.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				prod_s8[k][0] <= ctl_s7.mask[k] ? 64'(pts_s7[k].x * w_s7[k]) : '0;
				prod_s8[k][1] <= ctl_s7.mask[k] ? 64'(pts_s7[k].y * w_s7[k]) : '0;
				prod_s8[k][2] <= ctl_s7.mask[k] ? 64'(pts_s7[k].z * w_s7[k]) : '0;
			end
		end
	end

	// Stage eight: sum, round half up, shift, clamp to the divider range.
	always_comb begin
		logic signed [65:0] acc;
		logic signed [65:0] v;
		logic signed [65:0] lo;
		logic signed [65:0] hi;
		for (int j = 0; j < 3; j++) begin
			acc = 66'(prod_s8[0][j]) + 66'(prod_s8[1][j]) + 66'(prod_s8[2][j]) +
				66'(prod_s8[3][j]);
			case (ctl_s8.dsel)
				DIV_2: begin
					v  = (acc + 66'sh100_0000) >>> 25;
					lo = -66'sd2147483648;
					hi = 66'sd2147483647;
				end
				DIV_6: begin
					v  = (acc + 66'sh300_0000) >>> 25;
					lo = -66'sd6442450944;
					hi = 66'sd6442450943;
				end
				default: begin
					v  = (acc + 66'sh80_0000) >>> 24;
					lo = -66'sd2147483648;
					hi = 66'sd2147483647;
				end
			endcase
			if (v < lo) begin
				vc8[j] = 35'(lo);
			end else if (v > hi) begin
				vc8[j] = 35'(hi);
			end else begin
				vc8[j] = 35'(v);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vc_s9 <= vc8;
		end
	end

	// Stage nine: divide by three as a reciprocal product in two halves.
	always_ff @(posedge clk) begin
		logic [33:0] xo;
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				xo = 34'(vc_s9[j] + 35'sd6442450944);
				pph_s10[j] <= 51'(xo * DIV3_M[33:17]);
				ppl_s10[j] <= 51'(xo * DIV3_M[16:0]);
				vc_s10[j]  <= vc_s9[j];
			end
		end
	end

	// Stage ten: finish the quotient and select the result.
	always_ff @(posedge clk) begin
		logic [68:0] full;
		logic [33:0] quo;
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				full = {pph_s10[j], 17'd0} + 69'(ppl_s10[j]);
				quo  = full[68:35];
				if (ctl_s10.fault) begin
					res_s11[j] <= '0;
				end else if (ctl_s10.dsel == DIV_6) begin
					res_s11[j] <= 32'(quo - 34'h0_8000_0000);
				end else begin
					res_s11[j] <= vc_s10[j][31:0];
				end
			end
			fault_s11 <= ctl_s10.fault;
		end
	end

endmodule

### bench/tb_cubic_curve_point_and_tangent.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cubic_curve_point_and_tangent
// Self-checking bench for the cubic curve evaluator. A behavioral predictor
// computes each position or tangent beat from its own copy of the point store
// and registers. Directed beats cover the curve kinds, the parameter end
// points and ignored beats. Random phases under varied settings and a long
// receiver hold-off follow.
// ----------------------------------------------------------------------------
module tb_cubic_curve_point_and_tangent;
	import ccpt_pkg::*;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               fault;
	} curve_out_t;

	localparam longint Q24 = 64'sd1 << 24;
	localparam int STALL_LIMIT = 5000;

	logic               clk;
	logic               arst_n;
	logic               cfg_write_en;
	logic [1:0]         cfg_index;
	logic [19:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         mode;
	logic [7:0]         point_index;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic signed [31:0] coord_z;
	logic [16:0]        curve_param;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] result_x;
	logic signed [31:0] result_y;
	logic signed [31:0] result_z;
	logic               range_fault;

	// Predictor state.
	logic signed [31:0] shadow_x [STORE_DEPTH];
	logic signed [31:0] shadow_y [STORE_DEPTH];
	logic signed [31:0] shadow_z [STORE_DEPTH];
	kind_t              cur_kind;
	logic [7:0]         cur_points;
	longint             cur_tension;

	curve_out_t pending_curve[$];
	int         errors;
	int         quiet_cycles;
	int         burst_left;
	bit         no_gaps;
	int         hold_cycles;

	cubic_curve_point_and_tangent dut (.*);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint floor_div(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q--;
		return q;
	endfunction

	function automatic longint tens(longint v);
		return floor_div(cur_tension * v, 65536);
	endfunction

	function automatic logic signed [31:0] round_sat(longint acc, longint d);
		longint r;
		r = floor_div(acc + d * (64'sd1 << 23), d * Q24);
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r[31:0];
	endfunction

	// Works out the curve beat for one evaluation; returns 0 if none is due.
	function automatic bit eval_curve(logic [1:0] md, logic [16:0] u, output curve_out_t res);
		int unsigned n, seg, f, base, cnt, p;
		longint w[4];
		longint d, t1, t2, t3, ax, ay, az;
		longint unsigned ff;
		bit at_end;
		res = '{0, 0, 0, 1'b0};
		if (md != MODE_POS && md != MODE_TAN)
			return 0;
		if (u > T_ONE)
			return 0;
		n = cur_points < 2 ? 2 : cur_points;
		at_end = (u == T_ONE);
		seg = 0;
		f = 0;
		d = 1;
		cnt = 4;
		w = '{0, 0, 0, 0};
		if (!at_end) begin
			p = u * (n - 1);
			seg = p >> 16;
			f = p & 32'hFFFF;
		end
		if (md == MODE_POS && at_end && cur_kind != KIND_BSPLINE) begin
			cnt = 1;
			base = cur_kind == KIND_LINEAR ? n - 1 : (cur_kind == KIND_BEZIER ? 3 * (n - 1) : n);
			w[0] = Q24;
		end else begin
			if (at_end) begin
				seg = n - 2;
				f = (md == MODE_TAN && cur_kind == KIND_LINEAR) ? 0 : 65536;
			end
			ff = f;
			t1 = ff << 8;
			t2 = (ff * ff) >> 8;
			t3 = (ff * ff * ff) >> 24;
			base = cur_kind == KIND_BEZIER ? 3 * seg : seg;
			if (md == MODE_POS) begin
				case (cur_kind)
					KIND_LINEAR: begin
						cnt = 2; w[0] = Q24 - t1; w[1] = t1;
					end
					KIND_BEZIER: begin
						w[0] = Q24 - 3 * t1 + 3 * t2 - t3;
						w[1] = 3 * t1 - 6 * t2 + 3 * t3;
						w[2] = 3 * t2 - 3 * t3;
						w[3] = t3;
					end
					KIND_BSPLINE: begin
						d = 6;
						w[0] = Q24 - 3 * t1 + 3 * t2 - t3;
						w[1] = 3 * t3 - 6 * t2 + 4 * Q24;
						w[2] = 3 * (t2 - t3 + t1) + Q24;
						w[3] = t3;
					end
					default: begin
						w[0] = tens(2 * t2 - t3 - t1);
						w[1] = 2 * t3 - 3 * t2 + Q24 + tens(t2 - t3);
						w[2] = 3 * t2 - 2 * t3 + tens(t3 - 2 * t2 + t1);
						w[3] = tens(t3 - t2);
					end
				endcase
			end else begin
				case (cur_kind)
					KIND_LINEAR: begin
						cnt = 2; w[0] = -Q24; w[1] = Q24;
					end
					KIND_BEZIER: begin
						w[0] = -3 * Q24 + 6 * t1 - 3 * t2;
						w[1] = 3 * Q24 - 12 * t1 + 9 * t2;
						w[2] = 6 * t1 - 9 * t2;
						w[3] = 3 * t2;
					end
					KIND_BSPLINE: begin
						d = 2;
						w[0] = -(Q24 - 2 * t1 + t2);
						w[1] = 3 * t2 - 4 * t1;
						w[2] = -3 * t2 + 2 * t1 + Q24;
						w[3] = t2;
					end
					default: begin
						w[0] = tens(-3 * t2 + 4 * t1 - Q24);
						w[1] = 6 * t2 - 6 * t1 + tens(2 * t1 - 3 * t2);
						w[2] = -6 * t2 + 6 * t1 + tens(3 * t2 - 4 * t1 + Q24);
						w[3] = tens(3 * t2 - 2 * t1);
					end
				endcase
			end
		end
		// Any needed point past the store gives a fault beat of zeros.
		if (base + cnt > STORE_DEPTH) begin
			res.fault = 1'b1;
			return 1;
		end
		ax = 0;
		ay = 0;
		az = 0;
		for (int k = 0; k < cnt; k++) begin
			ax += longint'(shadow_x[base + k]) * w[k];
			ay += longint'(shadow_y[base + k]) * w[k];
			az += longint'(shadow_z[base + k]) * w[k];
		end
		res.x = round_sat(ax, d);
		res.y = round_sat(ay, d);
		res.z = round_sat(az, d);
		return 1;
	endfunction

	// Sends one beat, keeping valid high while the burst lasts.
	task automatic send_beat(logic [1:0] md, logic [7:0] idx, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z, logic [16:0] u);
		curve_out_t res;
		@(negedge clk);
		in_valid    = 1'b1;
		mode        = md;
		point_index = idx;
		coord_x     = x;
		coord_y     = y;
		coord_z     = z;
		curve_param = u;
		do @(posedge clk); while (in_stall);
		if (md == MODE_LOAD) begin
			shadow_x[idx] = x;
			shadow_y[idx] = y;
			shadow_z[idx] = z;
		end else if (eval_curve(md, u, res)) begin
			pending_curve.push_back(res);
		end
		// Burst bookkeeping: drop valid and pause once a burst runs out.
		if (!no_gaps) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat ($urandom_range(0, 3) == 0 ? $urandom_range(5, 20) : $urandom_range(1, 3))
					@(negedge clk);
				burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80) : $urandom_range(0, 12);
			end
		end
	endtask

	// Waits until the block is idle; loads give no beat, so allow the latency too.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_curve.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [19:0] value);
		drain();
		cfg_write_en = 1'b1;
		cfg_index    = idx;
		cfg_data     = value;
		@(negedge clk);
		cfg_write_en = 1'b0;
		case (idx)
			CFG_KIND:   cur_kind = kind_t'(value[1:0]);
			CFG_POINTS: cur_points = value[7:0];
			default:    cur_tension = longint'($signed(value));
		endcase
	endtask

	task automatic set_curve(kind_t kind, logic [7:0] pts, logic [19:0] tension);
		write_reg(CFG_KIND, {18'd0, kind});
		write_reg(CFG_POINTS, {12'd0, pts});
		write_reg(CFG_TENSION, tension);
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2, 3:    return $urandom;
			default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
		endcase
	endfunction

	// Fills every store entry so that no evaluation reads an unwritten point.
	task automatic test_fill_store();
		for (int i = 0; i < STORE_DEPTH; i++)
			send_beat(MODE_LOAD, i[7:0], rand_coord(), rand_coord(), rand_coord(),
				17'($urandom));
	endtask

	// End points of the parameter, ignored beats and extreme point counts.
	task automatic test_directed();
		set_curve(KIND_LINEAR, 8'd2, 20'd32768);
		send_beat(MODE_LOAD, 8'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 17'd0);
		send_beat(MODE_LOAD, 8'd1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd65536, 17'd0);
		send_beat(MODE_POS, 8'd0, 0, 0, 0, 17'd0);
		send_beat(MODE_POS, 8'd0, 0, 0, 0, 17'h0_8000);
		send_beat(MODE_TAN, 8'd0, 0, 0, 0, 17'h0_8000);
		send_beat(MODE_POS, 8'd0, 0, 0, 0, T_ONE);
		send_beat(MODE_TAN, 8'd0, 0, 0, 0, T_ONE);
		send_beat(MODE_POS, 8'd0, 0, 0, 0, T_ONE + 17'd1);
		send_beat(MODE_TAN, 8'd0, 0, 0, 0, 17'h1_FFFF);
		send_beat(MODE_NONE, 8'hFF, 32'sh7FFF_FFFF, 0, 0, 17'd0);
		for (int k = 0; k < 4; k++) begin
			set_curve(kind_t'(k), 8'd255, 20'hF_0000);
			send_beat(MODE_POS, 8'd0, 0, 0, 0, 17'd0);
			send_beat(MODE_POS, 8'd0, 0, 0, 0, T_ONE);
			send_beat(MODE_TAN, 8'd0, 0, 0, 0, T_ONE);
			send_beat(MODE_TAN, 8'd0, 0, 0, 0, 17'h0_FFFF);
		end
	endtask

	task automatic random_beats(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				send_beat(MODE_LOAD, 8'($urandom), rand_coord(), rand_coord(), rand_coord(),
					17'($urandom));
			else if (r < 12)
				send_beat(MODE_NONE, 8'($urandom), $urandom, $urandom, $urandom,
					17'($urandom));
			else if (r < 18)
				send_beat(2'($urandom_range(1, 2)), 8'($urandom), $urandom, $urandom,
					$urandom, 17'($urandom_range(T_ONE + 1, 17'h1_FFFF)));
			else if (r < 24)
				send_beat(2'($urandom_range(1, 2)), 8'($urandom), $urandom, $urandom,
					$urandom, $urandom_range(0, 1) ? T_ONE : 17'd0);
			else
				send_beat(2'($urandom_range(1, 2)), 8'($urandom), $urandom, $urandom,
					$urandom, 17'($urandom_range(0, T_ONE)));
		end
	endtask

	// Phases under random and extreme settings.
	task automatic test_random_phases();
		logic [7:0]  pts;
		logic [19:0] tension;
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0:       pts = 8'($urandom_range(0, 3));
				1:       pts = 8'd255;
				default: pts = 8'($urandom_range(2, 255));
			endcase
			case (ph % 3)
				0:       tension = ph[0] ? 20'h7_FFFF : 20'h8_0000;
				1:       tension = 20'd0;
				default: tension = 20'($urandom);
			endcase
			set_curve(kind_t'(ph % 4), pts, tension);
			random_beats(120);
		end
	endtask

	// The receiver holds off while beats keep coming, so the input stalls.
	task automatic test_backpressure();
		set_curve(KIND_CARDINAL, 8'd40, 20'd32768);
		drain();
		no_gaps = 1'b1;
		hold_cycles = 300;
		random_beats(80);
		no_gaps = 1'b0;
	endtask

	// Receiver stall pattern, with a long hold-off on request.
	initial begin
		int phase_left;
		int stall_pct;
		out_stall  = 1'b1;
		phase_left = 0;
		stall_pct  = 0;
		forever begin
			@(negedge clk);
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 150);
				case ($urandom_range(0, 2))
					0:       stall_pct = 0;
					1:       stall_pct = 30;
					default: stall_pct = 75;
				endcase
			end
			phase_left--;
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall = 1'b1;
			end else begin
				out_stall = $urandom_range(0, 99) < stall_pct;
			end
		end
	end

	// Checks each accepted result beat against the oldest prediction.
	always @(posedge clk) begin
		curve_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_curve.size() == 0) begin
				$display("%0t: unexpected result beat x=%0d y=%0d z=%0d fault=%0b",
					$time, result_x, result_y, result_z, range_fault);
				errors++;
			end else begin
				want = pending_curve.pop_front();
				if (result_x !== want.x) begin
					$display("%0t: result_x expected %0d actual %0d", $time, want.x, result_x);
					errors++;
				end
				if (result_y !== want.y) begin
					$display("%0t: result_y expected %0d actual %0d", $time, want.y, result_y);
					errors++;
				end
				if (result_z !== want.z) begin
					$display("%0t: result_z expected %0d actual %0d", $time, want.z, result_z);
					errors++;
				end
				if (range_fault !== want.fault) begin
					$display("%0t: range_fault expected %0b actual %0b",
						$time, want.fault, range_fault);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles in which neither side accepts a beat.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_cubic_curve_point_and_tangent: FAIL");
			$finish;
		end
	end

	initial begin
		errors       = 0;
		quiet_cycles = 0;
		burst_left   = 0;
		no_gaps      = 1'b0;
		hold_cycles  = 0;
		arst_n       = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index    = CFG_KIND;
		cfg_data     = '0;
		in_valid     = 1'b0;
		mode         = MODE_LOAD;
		point_index  = '0;
		coord_x      = '0;
		coord_y      = '0;
		coord_z      = '0;
		curve_param  = '0;
		cur_kind     = KIND_LINEAR;
		cur_points   = 8'd2;
		cur_tension  = 32768;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_fill_store();
		test_directed();
		test_random_phases();
		test_backpressure();
		drain();
		repeat (20) @(negedge clk);

		if (errors == 0)
			$display("tb_cubic_curve_point_and_tangent: PASS");
		else
			$display("tb_cubic_curve_point_and_tangent: FAIL");
		$finish;
	end

endmodule
